// File: design/mtfrt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtfrt_pkg
// Shared types, codes and default sizes for the move-to-front rank tracker.
// ----------------------------------------------------------------------------
package mtfrt_pkg;

  localparam int DEF_MAX_ITEMS    = 1024;
  localparam int DEF_MAX_ACCESSES = 1024;

  localparam int CFG_W   = 11;
  localparam int ID_W    = 11;
  localparam int ABOVE_W = 10;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  typedef enum logic {
    FUNC_START  = 1'b0,
    FUNC_ACCESS = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_BAD_ID    = 2'd1,
    STATUS_NO_BUDGET = 2'd2
  } status_t;

  typedef enum logic {
    REG_ITEM_COUNT    = 1'b0,
    REG_ACCESS_BUDGET = 1'b1
  } reg_idx_t;

  typedef struct packed {
    func_t            func;
    logic [ID_W-1:0]  item_id;
  } mtfrt_in_t;

  typedef struct packed {
    logic [ABOVE_W-1:0] items_above;
    status_t            status;
  } mtfrt_out_t;

endpackage

// File: design/mtfrt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtfrt_ram
// Generic simple dual-port RAM with one write port and a registered read port.
// ----------------------------------------------------------------------------
module mtfrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/move_to_front_rank_tracker_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// move_to_front_rank_tracker_top
// Move-to-front list held as a slot array with a Fenwick count tree over the
// slots, both in RAM, walked one tree level at a time by a small sequencer.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake           Payload
//  in        input      in_valid/in_stall   mtfrt_in_t  (func, item_id)
//  out       output     out_valid/out_stall mtfrt_out_t (items_above, status)
//  config    input      APB write/read      item_count, access_budget
//
// An access reads the item's slot, sums the prefix count with one tree read
// per set bit of the slot index, then climbs the tree for two point updates
// (a decrement at the old slot, an increment at the new top slot), each level
// a read and then a write of the count-tree RAM. A start rebuilds the whole
// tree one node at a time.
// Reset is synchronous; no RAM clearing pass is needed after it. A stalled
// result stays in the output register while the next transfer is taken.
// ----------------------------------------------------------------------------
module move_to_front_rank_tracker_top #(
  parameter int MAX_ITEMS    = mtfrt_pkg::DEF_MAX_ITEMS,
  parameter int MAX_ACCESSES = mtfrt_pkg::DEF_MAX_ACCESSES
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  mtfrt_pkg::mtfrt_in_t          in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output mtfrt_pkg::mtfrt_out_t         out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mtfrt_pkg::PADDR_W-1:0] paddr,
  input  logic [mtfrt_pkg::PDATA_W-1:0] pwdata,
  output logic [mtfrt_pkg::PDATA_W-1:0] prdata,
  output logic                          pready
);

  import mtfrt_pkg::*;

  localparam int TREE_SLOTS = MAX_ITEMS + MAX_ACCESSES;
  localparam int TW = $clog2(TREE_SLOTS + 1);
  localparam int XW = TW + 1;
  localparam int SW = $clog2(TREE_SLOTS);
  localparam int IW = $clog2(MAX_ITEMS);
  localparam int NW = $clog2(MAX_ITEMS + 1);
  localparam int BW = $clog2(MAX_ACCESSES + 1);
  localparam int DW = NW;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BUILD_A,
    ST_BUILD_B,
    ST_SLOT_WAIT,
    ST_PRE_RD,
    ST_PRE_ACC,
    ST_UPD_RD,
    ST_UPD_WR,
    ST_RESULT
  } state_t;

  state_t           state;
  logic [CFG_W-1:0] item_count;
  logic [CFG_W-1:0] access_budget;
  logic             session_valid;
  logic [NW-1:0]    sess_items;
  logic [BW-1:0]    sess_budget;
  logic [BW-1:0]    next_top;
  logic [XW-1:0]    j;
  logic [XW-1:0]    lo;
  logic [XW-1:0]    hi;
  logic [XW-1:0]    idx;
  logic [SW-1:0]    slot;
  logic [DW-1:0]    acc;
  logic [IW-1:0]    id_addr;
  logic             dec_phase;
  status_t          res_status;

  logic             cfg_write;
  logic [NW-1:0]    n_clamped;
  logic [BW-1:0]    b_clamped;
  logic [SW-1:0]    dest;
  logic [XW-1:0]    lowbit_j;
  logic [XW-1:0]    range_start;
  logic [XW-1:0]    occ_end;
  logic [XW-1:0]    idx_clr;
  logic [XW-1:0]    idx_up;
  logic             out_free;
  logic             id_bad;

  logic             tree_we;
  logic [TW-1:0]    tree_waddr;
  logic [DW-1:0]    tree_wdata;
  logic [TW-1:0]    tree_raddr;
  logic [DW-1:0]    tree_rdata;
  logic             item_we;
  logic [IW-1:0]    item_waddr;
  logic [SW-1:0]    item_wdata;
  logic [IW-1:0]    item_raddr;
  logic [SW-1:0]    item_rdata;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign in_stall  = (state != ST_IDLE);
  assign out_free  = !out_valid || !out_stall;

  always_comb begin
    case (reg_idx_t'(paddr[2]))
      REG_ITEM_COUNT:    prdata = PDATA_W'(item_count);
      REG_ACCESS_BUDGET: prdata = PDATA_W'(access_budget);
      default:           prdata = '0;
    endcase
  end

  always_comb begin
    if (item_count == '0) begin
      n_clamped = NW'(1);
    end else if (32'(item_count) > MAX_ITEMS) begin
      n_clamped = NW'(MAX_ITEMS);
    end else begin
      n_clamped = NW'(item_count);
    end
    if (32'(access_budget) > MAX_ACCESSES) begin
      b_clamped = BW'(MAX_ACCESSES);
    end else begin
      b_clamped = BW'(access_budget);
    end
  end

  assign dest        = SW'(next_top - 1'b1);
  assign lowbit_j    = j & (~j + 1'b1);
  assign range_start = j - lowbit_j;
  assign occ_end     = XW'(sess_budget) + XW'(sess_items);
  assign idx_clr     = idx & (idx - 1'b1);
  assign idx_up      = idx + (idx & (~idx + 1'b1));
  assign id_bad      = (in_data.item_id == '0) ||
                       (32'(in_data.item_id) > 32'(sess_items));

  always_comb begin
    tree_we    = (state == ST_BUILD_B) || (state == ST_UPD_WR);
    tree_raddr = TW'(idx);
    if (state == ST_BUILD_B) begin
      tree_waddr = TW'(j);
      tree_wdata = (hi > lo) ? DW'(hi - lo) : '0;
    end else begin
      tree_waddr = TW'(idx);
      tree_wdata = dec_phase ? (tree_rdata - 1'b1) : (tree_rdata + 1'b1);
    end
  end

  always_comb begin
    item_raddr = IW'(in_data.item_id - 1'b1);
    if (state == ST_BUILD_B) begin
      item_we    = (32'(j) <= 32'(sess_items));
      item_waddr = IW'(j - 1'b1);
      item_wdata = SW'(XW'(sess_budget) + j - 1'b1);
    end else begin
      item_we    = (state == ST_RESULT) && out_free && (res_status == STATUS_OK);
      item_waddr = id_addr;
      item_wdata = dest;
    end
  end

  mtfrt_ram #(
    .WIDTH (DW),
    .DEPTH (TREE_SLOTS + 1)
  ) u_tree_ram (
    .clk   (clk),
    .we    (tree_we),
    .waddr (tree_waddr),
    .wdata (tree_wdata),
    .raddr (tree_raddr),
    .rdata (tree_rdata)
  );

  mtfrt_ram #(
    .WIDTH (SW),
    .DEPTH (MAX_ITEMS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (item_we),
    .waddr (item_waddr),
    .wdata (item_wdata),
    .raddr (item_raddr),
    .rdata (item_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      item_count    <= CFG_W'(1);
      access_budget <= '0;
      session_valid <= 1'b0;
      sess_items    <= '0;
      sess_budget   <= '0;
      next_top      <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (reg_idx_t'(paddr[2]))
          REG_ITEM_COUNT:    item_count    <= CFG_W'(pwdata);
          REG_ACCESS_BUDGET: access_budget <= CFG_W'(pwdata);
          default: ;
        endcase
      end
      if (out_valid && !out_stall && (state != ST_RESULT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            acc     <= '0;
            id_addr <= item_raddr;
            if (in_data.func == FUNC_START) begin
              sess_items    <= n_clamped;
              sess_budget   <= b_clamped;
              next_top      <= b_clamped;
              session_valid <= 1'b1;
              j             <= XW'(1);
              state         <= ST_BUILD_A;
            end else if (!session_valid) begin
              res_status <= STATUS_NO_BUDGET;
              state      <= ST_RESULT;
            end else if (id_bad) begin
              res_status <= STATUS_BAD_ID;
              state      <= ST_RESULT;
            end else if (next_top == '0) begin
              res_status <= STATUS_NO_BUDGET;
              state      <= ST_RESULT;
            end else begin
              res_status <= STATUS_OK;
              state      <= ST_SLOT_WAIT;
            end
          end
        end
        ST_BUILD_A: begin
          lo    <= (range_start > XW'(sess_budget)) ? range_start : XW'(sess_budget);
          hi    <= (j < occ_end) ? j : occ_end;
          state <= ST_BUILD_B;
        end
        ST_BUILD_B: begin
          if (32'(j) >= TREE_SLOTS) begin
            state <= ST_IDLE;
          end else begin
            j     <= j + 1'b1;
            state <= ST_BUILD_A;
          end
        end
        ST_SLOT_WAIT: begin
          slot <= item_rdata;
          acc  <= '0;
          if (item_rdata == '0) begin
            idx       <= XW'(1);
            dec_phase <= 1'b1;
            state     <= ST_UPD_RD;
          end else begin
            idx   <= XW'(item_rdata);
            state <= ST_PRE_RD;
          end
        end
        ST_PRE_RD: begin
          state <= ST_PRE_ACC;
        end
        ST_PRE_ACC: begin
          acc <= acc + tree_rdata;
          if (idx_clr == '0) begin
            idx       <= XW'(slot) + 1'b1;
            dec_phase <= 1'b1;
            state     <= ST_UPD_RD;
          end else begin
            idx   <= idx_clr;
            state <= ST_PRE_RD;
          end
        end
        ST_UPD_RD: begin
          state <= ST_UPD_WR;
        end
        ST_UPD_WR: begin
          if (32'(idx_up) > TREE_SLOTS) begin
            if (dec_phase) begin
              dec_phase <= 1'b0;
              idx       <= XW'(dest) + 1'b1;
              state     <= ST_UPD_RD;
            end else begin
              state <= ST_RESULT;
            end
          end else begin
            idx   <= idx_up;
            state <= ST_UPD_RD;
          end
        end
        ST_RESULT: begin
          if (out_free) begin
            out_valid            <= 1'b1;
            out_data.items_above <= ABOVE_W'(acc);
            out_data.status      <= res_status;
            if (res_status == STATUS_OK) begin
              next_top <= next_top - 1'b1;
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // The free-slot count never climbs above the budget latched at start.
  assert property (@(posedge clk) disable iff (rst)
    session_valid |-> (next_top <= sess_budget))
    else $error("free top slot count above session budget");

  // A successful access consumes exactly one top slot.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !$past(out_valid) && out_data.status == STATUS_OK) |->
      (next_top == $past(next_top) - 1'b1))
    else $error("successful access did not consume one top slot");

  // A prefix count can never exceed the number of items in the session.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_PRE_RD || state == ST_UPD_RD) |-> (acc <= sess_items))
    else $error("prefix count exceeds item count");

endmodule

// File: bench/move_to_front_rank_tracker_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// move_to_front_rank_tracker_top_test
// Self-checking bench for the move-to-front rank tracker. A directed table
// covers the register extremes, clamping, every status code and sessions at
// both ends of the size range. Random sessions follow, mostly well-formed
// access runs with some noise. Each result is checked against a
// slot-occupancy predictor kept inside the bench, with random idling on both
// channels and one long hold-off on the output.
// ----------------------------------------------------------------------------
module move_to_front_rank_tracker_top_test;
  import mtfrt_pkg::*;

  localparam int NSLOTS       = DEF_MAX_ITEMS + DEF_MAX_ACCESSES;
  localparam int START_CYCLES = 2 * NSLOTS + 64;
  localparam int TAIL_CYCLES  = 200;
  localparam int HOLD_CYCLES  = 600;
  localparam int RAND_ITEMS   = 1100;
  localparam int QUIET_ITEMS  = 150;
  localparam int LIMIT        = 2_000_000;

  typedef enum bit {ROW_WR, ROW_ITEM} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    reg_idx_t    ridx;
    logic [31:0] value;
    mtfrt_in_t   item;
    bit          typed;
    mtfrt_out_t  want;
  } row_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  mtfrt_in_t          in_data;
  logic               out_valid;
  logic               out_stall;
  mtfrt_out_t         out_data;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  move_to_front_rank_tracker_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // Predictor state: register copies, latched session sizes and slot map.
  logic [CFG_W-1:0] reg_items;
  logic [CFG_W-1:0] reg_budget;
  int unsigned      list_slot [DEF_MAX_ITEMS];
  bit               slot_used [NSLOTS];
  int unsigned      free_top;
  bit               live;
  int unsigned      live_n;

  mtfrt_out_t pending_ranks [$];
  row_t       dir_rows [$];

  int  errors;
  int  cycles;
  int  n_sent;
  int  n_checked;
  int  n_starts;
  int  n_backpressure;
  bit  quiet;
  bit  hold_req;
  bit  last_start;

  initial begin
    clk = 1'b0;
  end

  always #5 clk = ~clk;

  function automatic int unsigned clamp_items(int unsigned v);
    if (v < 1) return 1;
    if (v > DEF_MAX_ITEMS) return DEF_MAX_ITEMS;
    return v;
  endfunction

  function automatic int unsigned clamp_budget(int unsigned v);
    if (v > DEF_MAX_ACCESSES) return DEF_MAX_ACCESSES;
    return v;
  endfunction

  function automatic bit predict_rank(input mtfrt_in_t it, output mtfrt_out_t res);
    int unsigned n;
    int unsigned b;
    int unsigned s;
    int unsigned cnt;
    res = '0;
    res.status = STATUS_OK;
    if (it.func == FUNC_START) begin
      n = clamp_items(reg_items);
      b = clamp_budget(reg_budget);
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      for (int i = 0; i < n; i++) begin
        list_slot[i] = b + i;
        slot_used[b + i] = 1'b1;
      end
      live_n = n;
      free_top = b;
      live = 1'b1;
      return 1'b0;
    end
    if (!live) begin
      res.status = STATUS_NO_BUDGET;
    end else if (it.item_id == 0 || it.item_id > live_n) begin
      res.status = STATUS_BAD_ID;
    end else if (free_top == 0) begin
      res.status = STATUS_NO_BUDGET;
    end else begin
      s = list_slot[it.item_id - 1];
      cnt = 0;
      for (int i = 0; i < s; i++) cnt += slot_used[i];
      slot_used[s] = 1'b0;
      free_top--;
      slot_used[free_top] = 1'b1;
      list_slot[it.item_id - 1] = free_top;
      res.items_above = cnt[ABOVE_W-1:0];
    end
    return 1'b1;
  endfunction

  function automatic row_t wr_row(reg_idx_t r, int unsigned v);
    row_t x;
    x.kind  = ROW_WR;
    x.ridx  = r;
    x.value = v;
    x.item  = '0;
    x.typed = 1'b0;
    x.want  = '0;
    return x;
  endfunction

  function automatic row_t item_row(func_t f, int unsigned id, bit typed = 1'b0,
                                    int unsigned above = 0, status_t st = STATUS_OK);
    row_t x;
    x.kind             = ROW_ITEM;
    x.ridx             = REG_ITEM_COUNT;
    x.value            = '0;
    x.item.func        = f;
    x.item.item_id     = id[ID_W-1:0];
    x.typed            = typed;
    x.want.items_above = above[ABOVE_W-1:0];
    x.want.status      = st;
    return x;
  endfunction

  function automatic logic [31:0] with_junk(int unsigned v);
    if ($urandom_range(0, 3) == 0) return v | ($urandom & 32'hFFFF_F800);
    return v;
  endfunction

  task automatic hold_input();
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic send_item(mtfrt_in_t it, bit typed = 1'b0, mtfrt_out_t want = '0);
    mtfrt_out_t res;
    if (!quiet && $urandom_range(0, 5) == 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_data  = it;
    do @(posedge clk); while (in_stall);
    if (predict_rank(it, res)) begin
      pending_ranks.push_back(typed ? want : res);
      last_start = 1'b0;
    end else begin
      last_start = 1'b1;
      n_starts++;
    end
    n_sent++;
  endtask

  task automatic apb_xfer(bit wr, reg_idx_t r, logic [31:0] wd, output logic [31:0] rd);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = PADDR_W'({r, 2'b00});
    pwdata  = wd;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic cfg_write(reg_idx_t r, logic [31:0] v);
    logic [31:0] rd;
    hold_input();
    while (pending_ranks.size() != 0) @(posedge clk);
    if (last_start) repeat (START_CYCLES) @(posedge clk);
    last_start = 1'b0;
    apb_xfer(1'b1, r, v, rd);
    if (r == REG_ITEM_COUNT) reg_items = v[CFG_W-1:0];
    else reg_budget = v[CFG_W-1:0];
    apb_xfer(1'b0, r, '0, rd);
    if (rd[CFG_W-1:0] !== v[CFG_W-1:0]) begin
      $display("%0t: register %0d read back: expected %0d, actual %0d",
               $time, r, v[CFG_W-1:0], rd[CFG_W-1:0]);
      errors++;
    end
  endtask

  // Output side: random stall bursts, plus one long hold-off on request.
  initial begin
    int burst;
    int hold;
    burst = 0;
    hold = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold = HOLD_CYCLES;
      end
      if (hold > 0) begin
        hold--;
        out_stall = 1'b1;
      end else if (burst > 0) begin
        burst--;
        out_stall = 1'b1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        burst = $urandom_range(0, 16);
        out_stall = 1'b1;
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    mtfrt_out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_ranks.size() == 0) begin
        $display("%0t: unexpected transfer out: items_above %0d status %0d",
                 $time, out_data.items_above, out_data.status);
        errors++;
      end else begin
        want = pending_ranks.pop_front();
        n_checked++;
        if (out_data.items_above !== want.items_above) begin
          $display("%0t: items_above: expected %0d, actual %0d",
                   $time, want.items_above, out_data.items_above);
          errors++;
        end
        if (out_data.status !== want.status) begin
          $display("%0t: status: expected %0d, actual %0d",
                   $time, want.status, out_data.status);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (in_valid && in_stall) n_backpressure++;
    if (cycles > LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    mtfrt_in_t   it;
    int unsigned n_eff;
    int unsigned b_eff;
    int unsigned acc;
    int unsigned sel;
    int unsigned dir_n;
    bit          first;

    rst        = 1'b1;
    in_valid   = 1'b0;
    in_data    = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    errors     = 0;
    cycles     = 0;
    n_sent     = 0;
    n_checked  = 0;
    n_starts   = 0;
    n_backpressure = 0;
    quiet      = 1'b0;
    hold_req   = 1'b0;
    last_start = 1'b0;
    reg_items  = 1;
    reg_budget = 0;
    live       = 1'b0;
    live_n     = 0;
    free_top   = 0;
    foreach (slot_used[i]) slot_used[i] = 1'b0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    dir_rows.push_back(item_row(FUNC_ACCESS, 1, 1'b1, 0, STATUS_NO_BUDGET));
    dir_rows.push_back(wr_row(REG_ITEM_COUNT, 5));
    dir_rows.push_back(wr_row(REG_ACCESS_BUDGET, 3));
    dir_rows.push_back(item_row(FUNC_START, 0));
    dir_rows.push_back(item_row(FUNC_ACCESS, 0, 1'b1, 0, STATUS_BAD_ID));
    dir_rows.push_back(item_row(FUNC_ACCESS, 6, 1'b1, 0, STATUS_BAD_ID));
    dir_rows.push_back(item_row(FUNC_ACCESS, 2047, 1'b1, 0, STATUS_BAD_ID));
    dir_rows.push_back(item_row(FUNC_ACCESS, 1, 1'b1, 0, STATUS_OK));
    dir_rows.push_back(item_row(FUNC_ACCESS, 5));
    dir_rows.push_back(item_row(FUNC_ACCESS, 3));
    dir_rows.push_back(item_row(FUNC_ACCESS, 1, 1'b1, 0, STATUS_NO_BUDGET));
    dir_rows.push_back(item_row(FUNC_ACCESS, 0, 1'b1, 0, STATUS_BAD_ID));
    dir_rows.push_back(wr_row(REG_ITEM_COUNT, 0));
    dir_rows.push_back(wr_row(REG_ACCESS_BUDGET, 0));
    dir_rows.push_back(item_row(FUNC_START, 2047));
    dir_rows.push_back(item_row(FUNC_ACCESS, 1, 1'b1, 0, STATUS_NO_BUDGET));
    dir_rows.push_back(item_row(FUNC_ACCESS, 2, 1'b1, 0, STATUS_BAD_ID));
    dir_rows.push_back(wr_row(REG_ITEM_COUNT, 2047));
    dir_rows.push_back(wr_row(REG_ACCESS_BUDGET, 2047));
    dir_rows.push_back(item_row(FUNC_START, 0));
    dir_rows.push_back(item_row(FUNC_ACCESS, 1024, 1'b1, 1023, STATUS_OK));
    dir_rows.push_back(item_row(FUNC_ACCESS, 1024, 1'b1, 0, STATUS_OK));
    dir_rows.push_back(item_row(FUNC_ACCESS, 1, 1'b1, 1, STATUS_OK));
    dir_rows.push_back(item_row(FUNC_ACCESS, 1025, 1'b1, 0, STATUS_BAD_ID));
    dir_rows.push_back(wr_row(REG_ITEM_COUNT, 3));
    dir_rows.push_back(item_row(FUNC_ACCESS, 500));
    dir_rows.push_back(item_row(FUNC_START, 0));
    dir_rows.push_back(item_row(FUNC_ACCESS, 4, 1'b1, 0, STATUS_BAD_ID));
    dir_rows.push_back(item_row(FUNC_ACCESS, 3));

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_WR) cfg_write(dir_rows[i].ridx, dir_rows[i].value);
      else send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
    end

    dir_n = n_sent;
    first = 1'b1;
    while (n_sent < dir_n + RAND_ITEMS) begin
      quiet = (n_sent >= dir_n + RAND_ITEMS - QUIET_ITEMS);
      sel = $urandom_range(0, 9);
      if (first || sel != 2) begin
        if (first) begin
          n_eff = $urandom_range(16, 64);
          b_eff = 40;
        end else if (sel == 0) begin
          n_eff = $urandom_range(0, 1) ? 1024 : $urandom_range(1025, 2047);
          b_eff = $urandom_range(0, 1) ? $urandom_range(1024, 2047) : $urandom_range(64, 1023);
        end else if (sel == 1) begin
          n_eff = $urandom_range(0, 1);
          b_eff = $urandom_range(0, 3);
        end else begin
          n_eff = $urandom_range(1, 64);
          b_eff = $urandom_range(0, 48);
        end
        cfg_write(REG_ITEM_COUNT, with_junk(n_eff));
        cfg_write(REG_ACCESS_BUDGET, with_junk(b_eff));
      end
      n_eff = clamp_items(reg_items);
      b_eff = clamp_budget(reg_budget);
      it.func = FUNC_START;
      it.item_id = ID_W'($urandom_range(0, 2047));
      send_item(it);
      acc = (b_eff > 80 ? 80 : b_eff) + $urandom_range(0, 4);
      for (int k = 0; k < acc; k++) begin
        if (!quiet && !first && $urandom_range(0, 29) == 0)
          cfg_write(reg_idx_t'($urandom_range(0, 1)), with_junk($urandom_range(0, 2047)));
        sel = $urandom_range(0, 39);
        it.func = FUNC_ACCESS;
        if (sel == 0) begin
          it.func = FUNC_START;
          it.item_id = ID_W'($urandom_range(0, 2047));
        end else if (sel < 5) begin
          it.item_id = ID_W'($urandom_range(0, 2047));
        end else if (sel == 5) begin
          it.item_id = ID_W'($urandom_range(0, 1) ? 0 : n_eff + 1);
        end else begin
          it.item_id = ID_W'($urandom_range(1, n_eff));
        end
        send_item(it);
        if (first && k == 0) hold_req = 1'b1;
      end
      first = 1'b0;
    end

    hold_input();
    while (pending_ranks.size() != 0) @(posedge clk);
    repeat (last_start ? START_CYCLES : TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d input transfers over %0d sessions and checked %0d results.",
             n_sent, n_starts, n_checked);
    $display("Input was held back for %0d cycles; %0d mismatches were found.",
             n_backpressure, errors);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
